/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is low
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* hw/rtl/obj_fip_pkg.sv */
// Package for the face index parser: widths, character codes, phase codes,
// register indexes and the structs passed between parser and resolver.
// No dependencies.
package obj_fip_pkg;

    // Accumulator width and derived constants
    localparam int INDEX_BITS = 24;
    localparam int COUNT_W    = 24;
    localparam int IDX_W      = 25;
    localparam int CALC_W     = ((INDEX_BITS > COUNT_W) ? INDEX_BITS : COUNT_W) + 1;
    localparam int PUSH_W     = INDEX_BITS + 4;
    localparam logic [INDEX_BITS-1:0] ACC_MAX = '1;

    // Stream payload layout
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 80;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_VERTEX_COUNT   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TEXCOORD_COUNT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_NORMAL_COUNT   = 2'd2;

    // Character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // Parse phases
    localparam int PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PH_IDLE = 3'd0;
    localparam logic [PHASE_W-1:0] PH_V    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_TS   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_T    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_NS   = 3'd4;
    localparam logic [PHASE_W-1:0] PH_N    = 3'd5;

    // Open token: accumulated magnitudes and sign flags
    typedef struct packed {
        logic [INDEX_BITS-1:0] v_acc;
        logic [INDEX_BITS-1:0] t_acc;
        logic [INDEX_BITS-1:0] n_acc;
        logic                  v_neg;
        logic                  t_neg;
        logic                  n_neg;
    } t_token;

    // What the current beat causes
    typedef struct packed {
        logic emit;
        logic corner;
        logic face_end;
    } t_event;

endpackage

/* hw/rtl/obj_fip_parse.sv */
// Per-character parser: phase register, accumulators and sign flags.
// Depends on obj_fip_pkg.
module obj_fip_parse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_char,
    input  logic                 i_eol,
    output obj_fip_pkg::t_token  o_tok,
    output obj_fip_pkg::t_event  o_evt
);
    import obj_fip_pkg::*;

    logic [PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0] n_phase;
    t_token             r_tok;
    t_token             n_tok;
    logic               ended;
    logic               is_digit;
    logic               is_minus;
    logic               is_slash;
    logic [3:0]         digit_val;
    logic [7:0]         char_off;

    // Multiply by ten, add the digit and saturate
    function automatic logic [INDEX_BITS-1:0] acc_push(
        input logic [INDEX_BITS-1:0] acc,
        input logic [3:0]            d
    );
        logic [PUSH_W-1:0] w;
        logic [PUSH_W-1:0] s;
        w = PUSH_W'(acc);
        s = (w << 3) + (w << 1) + PUSH_W'(d);
        if (s > PUSH_W'(ACC_MAX)) begin
            return ACC_MAX;
        end
        return s[INDEX_BITS-1:0];
    endfunction

    // Classify the character
    assign char_off  = i_char - CH_ZERO;
    assign digit_val = char_off[3:0];
    assign is_digit  = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign is_minus  = (i_char == CH_MINUS);
    assign is_slash  = (i_char == CH_SLASH);

    // Next phase and token contents
    always_comb begin
        n_phase = r_phase;
        n_tok   = r_tok;
        ended   = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (is_minus) begin
                    n_tok.v_neg = 1'b1;
                    n_phase     = PH_V;
                end else if (is_digit) begin
                    n_tok.v_acc = INDEX_BITS'(digit_val);
                    n_phase     = PH_V;
                end
            end
            PH_V: begin
                if (is_digit) begin
                    n_tok.v_acc = acc_push(r_tok.v_acc, digit_val);
                end else if (is_slash) begin
                    n_phase = PH_TS;
                end else begin
                    ended = 1'b1;
                end
            end
            PH_TS: begin
                if (is_minus) begin
                    n_tok.t_neg = 1'b1;
                    n_phase     = PH_T;
                end else if (is_digit) begin
                    n_tok.t_acc = INDEX_BITS'(digit_val);
                    n_phase     = PH_T;
                end else if (is_slash) begin
                    n_phase = PH_NS;
                end else begin
                    ended = 1'b1;
                end
            end
            PH_T: begin
                if (is_digit) begin
                    n_tok.t_acc = acc_push(r_tok.t_acc, digit_val);
                end else if (is_slash) begin
                    n_phase = PH_NS;
                end else begin
                    ended = 1'b1;
                end
            end
            PH_NS: begin
                if (is_minus) begin
                    n_tok.n_neg = 1'b1;
                    n_phase     = PH_N;
                end else if (is_digit) begin
                    n_tok.n_acc = INDEX_BITS'(digit_val);
                    n_phase     = PH_N;
                end else begin
                    ended = 1'b1;
                end
            end
            PH_N: begin
                if (is_digit) begin
                    n_tok.n_acc = acc_push(r_tok.n_acc, digit_val);
                end else begin
                    ended = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
        // Line end closes any token still open
        if (i_eol && (n_phase != PH_IDLE)) begin
            ended = 1'b1;
        end
    end

    assign o_tok          = n_tok;
    assign o_evt.emit     = ended || i_eol;
    assign o_evt.corner   = ended;
    assign o_evt.face_end = i_eol;

    // Advance on each beat; drop the token once it has been emitted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tok   <= '0;
        end else if (i_accept) begin
            if (o_evt.emit) begin
                r_phase <= PH_IDLE;
                r_tok   <= '0;
            end else begin
                r_phase <= n_phase;
                r_tok   <= n_tok;
            end
        end
    end

endmodule

/* hw/rtl/obj_fip_resolve.sv */
// Resolves relative indices, converts to zero-based and holds the result beat.
// Depends on obj_fip_pkg.
module obj_fip_resolve (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  obj_fip_pkg::t_event                 i_evt,
    input  obj_fip_pkg::t_token                 i_tok,
    input  logic [obj_fip_pkg::COUNT_W-1:0]     i_vertex_count,
    input  logic [obj_fip_pkg::COUNT_W-1:0]     i_texcoord_count,
    input  logic [obj_fip_pkg::COUNT_W-1:0]     i_normal_count,
    input  logic                                i_m_tready,
    output logic                                o_m_tvalid,
    output logic [obj_fip_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    output logic                                o_m_tlast,
    output logic                                o_slot_free
);
    import obj_fip_pkg::*;

    logic                  r_valid;
    logic [OUT_DATA_W-1:0] r_data;
    logic                  r_last;
    logic [OUT_DATA_W-1:0] n_data;
    logic [CALC_W-1:0]     v_dec;
    logic [CALC_W-1:0]     t_dec;
    logic [CALC_W-1:0]     n_dec;
    logic                  t_ok;
    logic                  n_ok;

    // Resolved index minus one: count - acc when negative, else acc - 1
    function automatic logic [CALC_W-1:0] resolve_dec(
        input logic [INDEX_BITS-1:0] acc,
        input logic                  neg,
        input logic [COUNT_W-1:0]    cnt
    );
        if (neg) begin
            return CALC_W'(cnt) - CALC_W'(acc);
        end
        return CALC_W'(acc) - CALC_W'(1);
    endfunction

    assign v_dec = resolve_dec(i_tok.v_acc, i_tok.v_neg, i_vertex_count);
    assign t_dec = resolve_dec(i_tok.t_acc, i_tok.t_neg, i_texcoord_count);
    assign n_dec = resolve_dec(i_tok.n_acc, i_tok.n_neg, i_normal_count);

    // A resolved index of zero shows as all ones after the decrement
    assign t_ok = (t_dec != '1);
    assign n_ok = (n_dec != '1);

    // Pack the result beat; all fields zero when no corner ends here
    always_comb begin
        n_data = '0;
        if (i_evt.corner) begin
            n_data[0]                 = 1'b1;
            n_data[IDX_W:1]           = v_dec[IDX_W-1:0];
            n_data[IDX_W+1]           = t_ok;
            n_data[2*IDX_W+1:IDX_W+2] = t_ok ? t_dec[IDX_W-1:0] : '0;
            n_data[2*IDX_W+2]         = n_ok;
            n_data[3*IDX_W+2:2*IDX_W+3] = n_ok ? n_dec[IDX_W-1:0] : '0;
        end
    end

    assign o_slot_free = !r_valid || i_m_tready;

    // Output register: hold while stalled, refill when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_slot_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_slot_free && i_load) begin
            r_data <= n_data;
            r_last <= i_evt.face_end;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tlast  = r_last;

endmodule

/* hw/rtl/obj_face_index_parser_top.sv */
// Face line corner parser: one character per input beat, at most one corner per
// result beat. Uses obj_fip_pkg, obj_fip_parse and obj_fip_resolve.
//
// Usage:
//  - Input stream carries the characters of a face line after the keyword,
//    one per beat; tlast marks the final character of the line.
//  - Output stream carries one beat per completed corner; the final character
//    of a line always gives a beat, shared with a corner that ends there, and
//    tlast marks that beat.
//  - Vertex, texcoord and normal counts are written through the plain write
//    port and serve as bases for negative (relative) indices.
//  - Throughput is one character per cycle while input ready is high. The
//    result of an accepted character is shown from the next cycle on,
//    held in a single output register.
//  - Input ready is high while the output register is empty or being taken
//    in the same cycle, so a stalled receiver holds the result beat and
//    stops all input, whether or not the next character gives a result.
//  - Synchronous active-low reset returns the parser to idle, clears all
//    counts and empties the output register.
module obj_face_index_parser_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port
    input  logic                                i_cfg_wr_en,
    input  logic [obj_fip_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [obj_fip_pkg::COUNT_W-1:0]     i_cfg_wdata,
    // Input stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [obj_fip_pkg::IN_DATA_W-1:0]   i_s_tdata,  // [7:0] char_code
    input  logic                                i_s_tlast,  // end_of_line
    // Output stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [0] corner_valid, [25:1] vertex_index, [26] texcoord_valid,
    // [51:27] texcoord_index, [52] normal_valid, [77:53] normal_index,
    // [79:78] zero
    output logic [obj_fip_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    output logic                                o_m_tlast   // face_end
);
    import obj_fip_pkg::*;

    logic [COUNT_W-1:0] r_vertex_count;
    logic [COUNT_W-1:0] r_texcoord_count;
    logic [COUNT_W-1:0] r_normal_count;
    logic               slot_free;
    logic               s_accept;
    t_token             tok;
    t_event             evt;

    // Count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count   <= '0;
            r_texcoord_count <= '0;
            r_normal_count   <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_VERTEX_COUNT:   r_vertex_count   <= i_cfg_wdata;
                REG_TEXCOORD_COUNT: r_texcoord_count <= i_cfg_wdata;
                REG_NORMAL_COUNT:   r_normal_count   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_s_tready = slot_free;
    assign s_accept   = i_s_tvalid && slot_free;

    obj_fip_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_accept),
        .i_char   (i_s_tdata),
        .i_eol    (i_s_tlast),
        .o_tok    (tok),
        .o_evt    (evt)
    );

    obj_fip_resolve u_resolve (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (s_accept && evt.emit),
        .i_evt            (evt),
        .i_tok            (tok),
        .i_vertex_count   (r_vertex_count),
        .i_texcoord_count (r_texcoord_count),
        .i_normal_count   (r_normal_count),
        .i_m_tready       (i_m_tready),
        .o_m_tvalid       (o_m_tvalid),
        .o_m_tdata        (o_m_tdata),
        .o_m_tlast        (o_m_tlast),
        .o_slot_free      (slot_free)
    );

endmodule

/* hw/rtl/obj_fip_checker.sv */
// Port-level checks for the face index parser, bound to the top level.
// Depends on obj_fip_pkg and assert_macros.svh.
`include "assert_macros.svh"

module obj_fip_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_tvalid,
    input logic                                o_s_tready,
    input logic                                i_s_tlast,
    input logic                                o_m_tvalid,
    input logic                                i_m_tready,
    input logic [obj_fip_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    input logic                                o_m_tlast
);
    import obj_fip_pkg::*;

    logic s_last_beat;
    logic rest_zero;
    logic tex_zero;

    // Shorthands for the checks below
    assign s_last_beat = i_s_tvalid && o_s_tready && i_s_tlast;
    assign rest_zero   = (o_m_tdata[OUT_DATA_W-1:1] == '0);
    assign tex_zero    = (o_m_tdata[2*IDX_W+1:IDX_W+2] == '0);

    // A stalled result beat stays offered
    `CHK_NEXT(a_hold_valid, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid)

    // A line's final character always yields a face-end beat next cycle
    `CHK_NEXT(a_eol_result, i_clk, i_rst_n, s_last_beat, o_m_tvalid && o_m_tlast)

    // Mid-line beats only come from completed corners
    `CHK_IMPLY(a_mid_corner, i_clk, i_rst_n, o_m_tvalid && !o_m_tlast, o_m_tdata[0])

    // No corner means every index field is zero
    `CHK_IMPLY(a_empty_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tdata[0], rest_zero)

    // An invalid texcoord carries a zero index
    `CHK_IMPLY(a_tex_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tdata[IDX_W+1], tex_zero)

endmodule

bind obj_face_index_parser_top obj_fip_checker u_obj_fip_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
